/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* hw/rtl/icmp_pkg.sv */
// shared types and constants of the icmp echo responder / matcher
// no dependencies
`default_nettype none
package icmp_pkg;
    localparam int REPLY_PAYLOAD_BYTES = 64;
    localparam int STORE_BYTES = 8 + REPLY_PAYLOAD_BYTES;
    localparam int STORE_WORDS = (STORE_BYTES + 1) / 2;
    localparam int WORD_AW = $clog2(STORE_WORDS);
    localparam int COPY_W = $clog2(STORE_BYTES + 1);
    localparam int MIN_ERROR_BYTES = 8 + 20 + 8;
    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] KIND_REPLY_WORD = 2'd0;
    localparam logic [1:0] KIND_ECHO_MATCH = 2'd1;
    localparam logic [1:0] KIND_UNREACH_MATCH = 2'd2;
    localparam logic [1:0] KIND_TIMEX_MATCH = 2'd3;

    localparam logic [1:0] CFG_AWAITING = 2'd0;
    localparam logic [1:0] CFG_EXP_ID = 2'd1;
    localparam logic [1:0] CFG_EXP_SEQ = 2'd2;
    localparam logic [1:0] CFG_ADDR_SET = 2'd3;

    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_UNREACH = 8'd3;
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    // one job handed from front to back
    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       peer;
        logic [COPY_W-1:0] reply_len;
        logic [22:0]       sum;
    } job_t;

    // byte write into the split store
    typedef struct packed {
        logic               en;
        logic               odd;
        logic [WORD_AW-1:0] addr;
        logic [7:0]         data;
    } store_wr_t;

    // back status toward front
    typedef struct packed {
        logic reply_done;
    } back_status_t;
endpackage
`default_nettype wire

/* hw/rtl/icmp_front.sv */
// front: accepts message bytes, tracks header fields and sum, classifies at packet end
// depends on icmp_pkg
`default_nettype none
module icmp_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_packet,
    input  wire logic [31:0]           sender_address,
    output icmp_pkg::store_wr_t        store_wr,
    output logic                       push,
    output icmp_pkg::job_t             push_job,
    input  wire logic                  fifo_full,
    input  wire icmp_pkg::back_status_t back_status,
    output logic                       reply_lock
);
    import icmp_pkg::*;

    logic        awaiting_reg, addr_set_reg;
    logic [15:0] exp_id_reg, exp_seq_reg;
    logic [15:0] count_reg, count_next, u_count;
    logic [7:0]  type_reg, type_next, u_type;
    logic [15:0] hid_reg, hid_next, u_hid;
    logic [15:0] hseq_reg, hseq_next, u_hseq;
    logic [5:0]  ihb_reg, ihb_next, u_ihb;
    logic [7:0]  proto_reg, proto_next, u_proto;
    logic [15:0] iid_reg, iid_next, u_iid;
    logic [15:0] iseq_reg, iseq_next, u_iseq;
    logic [22:0] sum_reg, sum_next, u_sum;
    logic        lock_reg, lock_next;
    logic        accept, in_store, err_ok;
    logic [15:0] base;
    logic [15:0] i;

    assign accept = in_valid && in_ready;
    assign in_ready = !fifo_full && !lock_reg;
    assign reply_lock = lock_reg;
    assign i = count_reg;
    assign in_store = i < 16'(STORE_BYTES);
    assign base = 16'd12 + 16'(ihb_reg);

    // store write port
    always_comb
    begin
        store_wr.en = accept && in_store;
        store_wr.odd = i[0];
        store_wr.addr = i[WORD_AW:1];
        store_wr.data = data_byte;
    end

    // field updates for the current byte
    always_comb
    begin
        u_count = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
        u_type = type_reg;
        u_hid = hid_reg;
        u_hseq = hseq_reg;
        u_ihb = ihb_reg;
        u_proto = proto_reg;
        u_iid = iid_reg;
        u_iseq = iseq_reg;
        u_sum = sum_reg;
        if (in_store && i >= 16'd4)
        begin
            u_sum = sum_reg + (i[0] ? {15'd0, data_byte} : {7'd0, data_byte, 8'd0});
        end
        if (i == 16'd0) u_type = data_byte;
        if (i == 16'd4) u_hid[15:8] = data_byte;
        if (i == 16'd5) u_hid[7:0] = data_byte;
        if (i == 16'd6) u_hseq[15:8] = data_byte;
        if (i == 16'd7) u_hseq[7:0] = data_byte;
        if (i == 16'd8) u_ihb = {data_byte[3:0], 2'b00};
        if (i == 16'd17) u_proto = data_byte;
        if (i >= 16'd9)
        begin
            if (i == base) u_iid[15:8] = data_byte;
            else if (i == base + 16'd1) u_iid[7:0] = data_byte;
            else if (i == base + 16'd2) u_iseq[15:8] = data_byte;
            else if (i == base + 16'd3) u_iseq[7:0] = data_byte;
        end
    end

    // classification at packet end
    assign err_ok = awaiting_reg && u_count >= 16'(MIN_ERROR_BYTES) && u_ihb >= 6'd20
        && (16'd16 + 16'(u_ihb)) <= u_count && u_proto == 8'd1
        && u_iid == exp_id_reg && u_iseq == exp_seq_reg;

    always_comb
    begin
        push = 1'b0;
        push_job.kind = KIND_REPLY_WORD;
        push_job.peer = sender_address;
        push_job.sum = u_sum;
        push_job.reply_len = (u_count < 16'(STORE_BYTES)) ? u_count[COPY_W-1:0]
            : COPY_W'(STORE_BYTES);
        if (accept && end_of_packet && u_count >= 16'd8)
        begin
            case (u_type)
                TYPE_ECHO_REPLY:
                begin
                    push = awaiting_reg && u_hid == exp_id_reg && u_hseq == exp_seq_reg;
                    push_job.kind = KIND_ECHO_MATCH;
                end
                TYPE_UNREACH:
                begin
                    push = err_ok;
                    push_job.kind = KIND_UNREACH_MATCH;
                end
                TYPE_TIME_EXCEEDED:
                begin
                    push = err_ok;
                    push_job.kind = KIND_TIMEX_MATCH;
                end
                TYPE_ECHO_REQUEST:
                begin
                    push = addr_set_reg;
                    push_job.kind = KIND_REPLY_WORD;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // next state; per-packet state clears after the final byte
    always_comb
    begin
        count_next = count_reg;
        type_next = type_reg;
        hid_next = hid_reg;
        hseq_next = hseq_reg;
        ihb_next = ihb_reg;
        proto_next = proto_reg;
        iid_next = iid_reg;
        iseq_next = iseq_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (end_of_packet)
            begin
                count_next = '0;
                type_next = '0;
                hid_next = '0;
                hseq_next = '0;
                ihb_next = '0;
                proto_next = '0;
                iid_next = '0;
                iseq_next = '0;
                sum_next = '0;
            end
            else
            begin
                count_next = u_count;
                type_next = u_type;
                hid_next = u_hid;
                hseq_next = u_hseq;
                ihb_next = u_ihb;
                proto_next = u_proto;
                iid_next = u_iid;
                iseq_next = u_iseq;
                sum_next = u_sum;
            end
        end
        lock_next = lock_reg;
        if (push && push_job.kind == KIND_REPLY_WORD) lock_next = 1'b1;
        else if (back_status.reply_done) lock_next = 1'b0;
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            addr_set_reg <= 1'b0;
            exp_id_reg <= '0;
            exp_seq_reg <= '0;
            count_reg <= '0;
            type_reg <= '0;
            hid_reg <= '0;
            hseq_reg <= '0;
            ihb_reg <= '0;
            proto_reg <= '0;
            iid_reg <= '0;
            iseq_reg <= '0;
            sum_reg <= '0;
            lock_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_AWAITING: awaiting_reg <= cfg_data[0];
                    CFG_EXP_ID: exp_id_reg <= cfg_data;
                    CFG_EXP_SEQ: exp_seq_reg <= cfg_data;
                    CFG_ADDR_SET: addr_set_reg <= cfg_data[0];
                    default: awaiting_reg <= awaiting_reg;
                endcase
            end
            count_reg <= count_next;
            type_reg <= type_next;
            hid_reg <= hid_next;
            hseq_reg <= hseq_next;
            ihb_reg <= ihb_next;
            proto_reg <= proto_next;
            iid_reg <= iid_next;
            iseq_reg <= iseq_next;
            sum_reg <= sum_next;
            lock_reg <= lock_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/icmp_fifo.sv */
// two-entry job queue between front and back
// depends on icmp_pkg
`default_nettype none
module icmp_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire icmp_pkg::job_t push_job,
    output logic                full,
    output logic                pop_valid,
    output icmp_pkg::job_t      pop_job,
    input  wire logic           pop
);
    import icmp_pkg::*;

    job_t       mem_reg [FIFO_DEPTH];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full = cnt_reg == 2'(FIFO_DEPTH);
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_job = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && pop_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/icmp_back.sv */
// back: holds the byte store, emits reports and echo reply words
// depends on icmp_pkg
`default_nettype none
module icmp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire icmp_pkg::store_wr_t store_wr,
    input  wire logic                job_valid,
    input  wire icmp_pkg::job_t      job,
    output logic                     job_pop,
    output icmp_pkg::back_status_t   status,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               result_kind,
    output logic [15:0]              reply_word,
    output logic [1:0]               word_bytes,
    output logic [31:0]              peer_address,
    output logic                     final_result
);
    import icmp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REPORT = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_LOAD   = 4'b1000
    } state_t;

    logic [7:0]         even_mem [STORE_WORDS];
    logic [7:0]         odd_mem [STORE_WORDS];
    logic [7:0]         even_rd_reg, odd_rd_reg;
    state_t             state_reg, state_next;
    job_t               job_reg;
    logic [15:0]        csum_reg;
    logic [WORD_AW-1:0] w_reg, w_next;
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        word_reg;
    logic [1:0]         nbytes_reg;
    logic [31:0]        peer_reg;
    logic               final_reg;
    logic               out_free, load;
    logic [16:0]        fold1;
    logic [16:0]        fold2;
    logic [COPY_W:0]    k_lo, k_end;
    logic [15:0]        word_val;
    logic [1:0]         nbytes_val;
    logic               final_val;

    // byte store, split into even and odd halves
    always_ff @(posedge clk)
    begin
        if (store_wr.en && !store_wr.odd) even_mem[store_wr.addr] <= store_wr.data;
        if (store_wr.en && store_wr.odd) odd_mem[store_wr.addr] <= store_wr.data;
        even_rd_reg <= even_mem[w_reg];
        odd_rd_reg <= odd_mem[w_reg];
    end

    // checksum folding of the job's word sum
    assign fold1 = {1'b0, job.sum[15:0]} + {10'd0, job.sum[22:16]};
    assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

    // current reply word
    assign k_lo = {1'b0, (COPY_W)'({w_reg, 1'b1})};
    assign k_end = {1'b0, (COPY_W)'({w_reg, 1'b0})} + (COPY_W + 1)'(2);
    always_comb
    begin
        nbytes_val = (k_lo < {1'b0, job_reg.reply_len}) ? 2'd2 : 2'd1;
        final_val = k_end >= {1'b0, job_reg.reply_len};
        if (w_reg == '0) word_val = 16'd0;
        else if (w_reg == WORD_AW'(1)) word_val = csum_reg;
        else word_val = {even_rd_reg, 8'd0};
        if (nbytes_val == 2'd2 && w_reg != '0 && w_reg != WORD_AW'(1))
        begin
            word_val[7:0] = odd_rd_reg;
        end
        if (nbytes_val == 2'd1) word_val[7:0] = 8'd0;
    end

    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        w_next = w_reg;
        job_pop = 1'b0;
        load = 1'b0;
        status.reply_done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    w_next = '0;
                    state_next = (job.kind == KIND_REPLY_WORD) ? ST_FETCH : ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (final_val)
                    begin
                        state_next = ST_IDLE;
                        status.reply_done = 1'b1;
                    end
                    else
                    begin
                        w_next = w_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            w_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg <= w_next;
            if (load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // job and output payload registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
            csum_reg <= ~fold2[15:0];
        end
        if (load)
        begin
            peer_reg <= job_reg.peer;
            kind_reg <= job_reg.kind;
            if (state_reg == ST_REPORT)
            begin
                word_reg <= 16'd0;
                nbytes_reg <= 2'd0;
                final_reg <= 1'b1;
            end
            else
            begin
                word_reg <= word_val;
                nbytes_reg <= nbytes_val;
                final_reg <= final_val;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result_kind = kind_reg;
    assign reply_word = word_reg;
    assign word_bytes = nbytes_reg;
    assign peer_address = peer_reg;
    assign final_result = final_reg;
endmodule
`default_nettype wire

/* hw/rtl/icmp_echo_responder_matcher.sv */
// ICMP echo responder and probe-answer matcher, top level
// Channels: the input takes one message byte per transaction (in_valid/in_ready) with
// end_of_packet on the final byte and the sender address. The output gives one result
// per transaction (out_valid/out_ready): reply words of an echo reply, or one match
// report. A config write port (cfg_write, cfg_index, cfg_data) sets the four registers.
// Throughput: one byte per cycle while no echo reply is pending and the job queue is not
// full. After the final byte of an echo request with an address assigned, input stalls
// until the last reply word is loaded into the output register: the back end reads the
// byte store one word at a time via a fetch and a load state, and waits in the load state
// while the output is stalled. Reports pass through a two-entry job queue and do not stop
// input unless the queue is full. The back end pops a job when idle and registers a report
// from its report state, or the first reply word from its load state after a fetch.
// Reset: control registers and per-packet state clear; the payload registers, the queue
// entries and the byte store are not cleared, and the store needs no clearing pass. When
// the receiver stalls, the output register holds and the queue, then the input, back up.
// Depends on icmp_pkg, icmp_front, icmp_fifo, icmp_back and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module icmp_echo_responder_matcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_packet,
    input  wire logic [31:0] sender_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [15:0]      reply_word,
    output logic [1:0]       word_bytes,
    output logic [31:0]      peer_address,
    output logic             final_result
);
    import icmp_pkg::*;

    store_wr_t    store_wr;
    logic         push, fifo_full, pop_valid, job_pop, reply_lock;
    job_t         push_job, pop_job;
    back_status_t back_status;

    // front end
    icmp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_packet  (end_of_packet),
        .sender_address (sender_address),
        .store_wr       (store_wr),
        .push           (push),
        .push_job       (push_job),
        .fifo_full      (fifo_full),
        .back_status    (back_status),
        .reply_lock     (reply_lock)
    );

    // job queue
    icmp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop       (job_pop)
    );

    // back end
    icmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .store_wr     (store_wr),
        .job_valid    (pop_valid),
        .job          (pop_job),
        .job_pop      (job_pop),
        .status       (back_status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .reply_word   (reply_word),
        .word_bytes   (word_bytes),
        .peer_address (peer_address),
        .final_result (final_result)
    );

    // checks
    `ASSERT_IMPLIES(a_lock_stalls, clk, rst_n, reply_lock, !in_ready)
    `ASSERT_IMPLIES(a_report_final, clk, rst_n, out_valid && result_kind != KIND_REPLY_WORD, final_result && word_bytes == 2'd0)
    `ASSERT_IMPLIES(a_word_bytes, clk, rst_n, out_valid && result_kind == KIND_REPLY_WORD, word_bytes == 2'd1 || word_bytes == 2'd2)
    `ASSERT_NEXT(a_no_write_locked, clk, rst_n, push && push_job.kind == KIND_REPLY_WORD, !store_wr.en)
endmodule
`default_nettype wire
